>>> rtl/mstsync_pkg.sv
// Shared types and constants for the multi-stream timestamp synchronizer.
`default_nettype none

package mstsync_pkg;

  localparam int NUM_SOURCES_DEF = 4;
  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int TS_W  = 62;
  localparam int TAG_W = 16;
  localparam int TOL_W = 32;
  localparam int KIND_W = 2;
  localparam int SRC_W  = 2;

  localparam logic [KIND_W-1:0] KIND_APPEND  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SRC_W-1:0]  source;
    logic [TS_W-1:0]   timestamp;
    logic [TAG_W-1:0]  tag;
  } in_item_t;

  typedef struct packed {
    logic [SRC_W-1:0] source_res;
    logic             present;
    logic [TS_W-1:0]  timestamp_res;
    logic [TAG_W-1:0] tag_res;
    logic             finished;
    logic             overflow;
    logic             last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic scan_init;
    logic rd_en;
    logic scan_cmp;
    logic win_calc;
    logic emit_load;
    logic emit_finished;
    logic emit_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic have;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/mstsync_dp.sv
// Datapath: per-source queues in one observation memory, pivot search and result register.
`default_nettype none

module mstsync_dp #(
  parameter int NUM_SOURCES = mstsync_pkg::NUM_SOURCES_DEF,
  parameter int QUEUE_DEPTH = mstsync_pkg::QUEUE_DEPTH_DEF,
  parameter int SW = $clog2(NUM_SOURCES)
) (
  input  wire                              clk,
  input  wire                              rst,
  input  mstsync_pkg::in_item_t            in_item,
  input  wire                              cfg_we,
  input  wire [mstsync_pkg::TOL_W-1:0]     cfg_wdata,
  input  mstsync_pkg::dp_cmd_t             cmd,
  input  wire [SW-1:0]                     idx,
  output mstsync_pkg::dp_stat_t            stat,
  output logic                             out_valid,
  input  wire                              out_stall,
  output mstsync_pkg::out_item_t           out_item
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = PW + 1;
  localparam int MEM_DEPTH = NUM_SOURCES << PW;
  localparam int EW = mstsync_pkg::TS_W + mstsync_pkg::TAG_W;
  localparam int WW = mstsync_pkg::TS_W + 1;

  logic [EW-1:0] mem [MEM_DEPTH];
  logic [EW-1:0] rd_data;

  logic [PW-1:0] rp   [NUM_SOURCES];
  logic [PW-1:0] wp   [NUM_SOURCES];
  logic [FW-1:0] fill [NUM_SOURCES];

  logic [mstsync_pkg::TOL_W-1:0] tolerance;
  logic                          overflow_flag;
  logic [mstsync_pkg::TS_W-1:0]  piv;
  logic                          have;
  logic [WW-1:0]                 win_end;

  logic [SW-1:0]                 sel;
  logic [PW-1:0]                 rp_sel;
  logic [PW-1:0]                 wp_sel;
  logic [FW-1:0]                 fill_sel;
  logic [PW-1:0]                 rp_inc;
  logic [PW-1:0]                 wp_inc;
  logic                          src_ok;
  logic                          do_append;
  logic                          do_clear;
  logic                          full;
  logic                          nonempty;
  logic [mstsync_pkg::TS_W-1:0]  head_ts;
  logic [mstsync_pkg::TAG_W-1:0] head_tag;
  logic                          hit;
  logic                          pop;

  // Appends index by the incoming source; scans and emits index by the controller's counter.
  assign sel      = cmd.take ? SW'(in_item.source) : idx;
  assign rp_sel   = rp[sel];
  assign wp_sel   = wp[sel];
  assign fill_sel = fill[sel];
  assign rp_inc   = (rp_sel == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_sel + PW'(1);
  assign wp_inc   = (wp_sel == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_sel + PW'(1);

  assign src_ok    = 32'(in_item.source) < NUM_SOURCES;
  assign do_append = cmd.take && (in_item.kind == mstsync_pkg::KIND_APPEND) && src_ok;
  assign do_clear  = cmd.take && (in_item.kind == mstsync_pkg::KIND_CLEAR);
  assign full      = fill_sel == FW'(QUEUE_DEPTH);

  assign nonempty = fill_sel != '0;
  assign head_ts  = rd_data[EW-1:mstsync_pkg::TAG_W];
  assign head_tag = rd_data[mstsync_pkg::TAG_W-1:0];
  assign hit      = nonempty && (head_ts >= piv) && ({1'b0, head_ts} <= win_end);
  assign pop      = cmd.emit_load && hit;

  assign stat.have     = have;
  assign stat.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (do_append && !full) begin
      mem[{sel, wp_sel}] <= {in_item.timestamp, in_item.tag};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[{sel, rp_sel}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        rp[s]   <= '0;
        wp[s]   <= '0;
        fill[s] <= '0;
      end
    end else if (do_append && !full) begin
      wp[sel]   <= wp_inc;
      fill[sel] <= fill_sel + FW'(1);
    end else if (pop) begin
      rp[sel]   <= rp_inc;
      fill[sel] <= fill_sel - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance     <= '0;
      overflow_flag <= 1'b0;
    end else begin
      if (cfg_we) begin
        tolerance <= cfg_wdata;
      end
      if (do_append && full) begin
        overflow_flag <= 1'b1;
      end
    end
  end

  // The pivot is the oldest non-empty head; a strict compare keeps the lowest source on a tie.
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_init) begin
      have <= 1'b0;
    end else if (cmd.scan_cmp && nonempty && (!have || head_ts < piv)) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_cmp && nonempty && (!have || head_ts < piv)) begin
      piv <= head_ts;
    end
    if (cmd.win_calc) begin
      win_end <= {1'b0, piv} + WW'(tolerance);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load || cmd.emit_finished) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_finished) begin
      out_item.source_res    <= '0;
      out_item.present       <= 1'b0;
      out_item.timestamp_res <= '0;
      out_item.tag_res       <= '0;
      out_item.finished      <= 1'b1;
      out_item.overflow      <= overflow_flag;
      out_item.last          <= 1'b1;
    end else if (cmd.emit_load) begin
      out_item.source_res    <= mstsync_pkg::SRC_W'(idx);
      out_item.present       <= hit;
      out_item.timestamp_res <= hit ? head_ts : '0;
      out_item.tag_res       <= hit ? head_tag : '0;
      out_item.finished      <= 1'b0;
      out_item.overflow      <= overflow_flag;
      out_item.last          <= cmd.emit_last;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mstsync_ctrl.sv
// Controller: sequences the head scan, the window setup and the per-source result pass.
`default_nettype none

module mstsync_ctrl #(
  parameter int NUM_SOURCES = mstsync_pkg::NUM_SOURCES_DEF,
  parameter int SW = $clog2(NUM_SOURCES)
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  input  wire [mstsync_pkg::KIND_W-1:0]      in_kind,
  output logic                               in_stall,
  input  mstsync_pkg::dp_stat_t              stat,
  output mstsync_pkg::dp_cmd_t               cmd,
  output logic [SW-1:0]                      idx
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_WINDOW,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

  state_t state;
  logic   idx_last;
  logic   start_adv;

  assign idx_last  = idx == SW'(NUM_SOURCES - 1);
  assign in_stall  = state != S_IDLE;
  assign start_adv = cmd.take && (in_kind == mstsync_pkg::KIND_ADVANCE);

  always_comb begin
    cmd.take          = in_valid && (state == S_IDLE);
    cmd.scan_init     = in_valid && (state == S_IDLE) && (in_kind == mstsync_pkg::KIND_ADVANCE);
    cmd.rd_en         = (state == S_SCAN_RD) || (state == S_EMIT_RD);
    cmd.scan_cmp      = state == S_SCAN_CMP;
    cmd.win_calc      = (state == S_WINDOW) && stat.have;
    cmd.emit_finished = (state == S_WINDOW) && !stat.have && !stat.out_busy;
    cmd.emit_load     = (state == S_EMIT_OUT) && !stat.out_busy;
    cmd.emit_last     = idx_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start_adv) begin
            idx   <= '0;
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (idx_last) begin
            state <= S_WINDOW;
          end else begin
            idx   <= idx + SW'(1);
            state <= S_SCAN_RD;
          end
        end
        S_WINDOW: begin
          if (stat.have) begin
            idx   <= '0;
            state <= S_EMIT_RD;
          end else if (!stat.out_busy) begin
            state <= S_IDLE;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (!stat.out_busy) begin
            if (idx_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + SW'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/multi_stream_timestamp_sync.sv
// Top level of the multi-stream timestamp synchronizer.
`default_nettype none

// Holds one time-ordered queue of observations per source in a single observation memory of
// NUM_SOURCES * 2**clog2(QUEUE_DEPTH) entries, which needs no clearing pass after reset.
// Append and clear transactions do not stall the input. An advance stalls the input through
// the pivot scan, the window step and the result pass, or through the scan and the window
// step alone when every queue is empty, and further while the output is stalled: the
// memory has one registered read port, so each source head is read once in the pivot scan and
// once more in the result pass. An advance delivers NUM_SOURCES results in source order, the
// final one marked last, or a single finished result when every queue is empty. The overflow
// flag is sticky until reset; clear does not reset it.
// The tolerance register should be written only while no advance is in progress.
module multi_stream_timestamp_sync #(
  parameter int NUM_SOURCES = mstsync_pkg::NUM_SOURCES_DEF,
  parameter int QUEUE_DEPTH = mstsync_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  mstsync_pkg::in_item_t          in_item,
  output logic                           out_valid,
  input  wire                            out_stall,
  output mstsync_pkg::out_item_t         out_item,
  input  wire                            cfg_we,
  input  wire [mstsync_pkg::TOL_W-1:0]   cfg_wdata
);

  localparam int SW = $clog2(NUM_SOURCES);

  mstsync_pkg::dp_cmd_t  cmd;
  mstsync_pkg::dp_stat_t stat;
  logic [SW-1:0]         idx;

  mstsync_ctrl #(
    .NUM_SOURCES(NUM_SOURCES),
    .SW(SW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_kind(in_item.kind),
    .in_stall(in_stall),
    .stat(stat),
    .cmd(cmd),
    .idx(idx)
  );

  mstsync_dp #(
    .NUM_SOURCES(NUM_SOURCES),
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .SW(SW)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .in_item(in_item),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd(cmd),
    .idx(idx),
    .stat(stat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  // A result must never overwrite one that the receiver has not yet taken.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_load || cmd.emit_finished) |-> !stat.out_busy)
    else $error("result register loaded while a result is still stalled");

  // Memory reads happen only while the input is stalled, never beside an append.
  assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (in_stall && !cmd.take))
    else $error("memory read issued while a transaction can be accepted");

  // A finished result always closes its advance.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.finished) |-> (out_item.last && !out_item.present))
    else $error("finished result without last or with present set");

  // The input stalls only after an advance transaction has been accepted.
  assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && (in_item.kind == mstsync_pkg::KIND_ADVANCE)))
    else $error("input stalled without an accepted advance");

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the multi-stream timestamp synchronizer.
`timescale 1ns / 1ps

module tb;

  localparam int NSRC = mstsync_pkg::NUM_SOURCES_DEF;
  localparam int QDEPTH = mstsync_pkg::QUEUE_DEPTH_DEF;
  localparam int TS_W = mstsync_pkg::TS_W;
  localparam int TAG_W = mstsync_pkg::TAG_W;
  localparam int TOL_W = mstsync_pkg::TOL_W;
  localparam int KIND_W = mstsync_pkg::KIND_W;
  localparam int SRC_W = mstsync_pkg::SRC_W;
  localparam logic [KIND_W-1:0] KIND_APPEND = mstsync_pkg::KIND_APPEND;
  localparam logic [KIND_W-1:0] KIND_ADVANCE = mstsync_pkg::KIND_ADVANCE;
  localparam logic [KIND_W-1:0] KIND_CLEAR = mstsync_pkg::KIND_CLEAR;

  typedef mstsync_pkg::in_item_t in_item_t;
  typedef mstsync_pkg::out_item_t out_item_t;

  localparam int QUIET_LIMIT = 3000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [63:0] TS_MAX = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam out_item_t FIN_CLEAN = {2'd0, 1'b0, 62'd0, 16'd0, 1'b1, 1'b0, 1'b1};
  localparam out_item_t MAX_HEAD = {2'd0, 1'b1, TS_MAX[TS_W-1:0], 16'hFFFF, 1'b0, 1'b0, 1'b0};

  typedef struct packed {
    logic [TS_W-1:0]  ts;
    logic [TAG_W-1:0] tag;
  } obs_t;

  typedef struct packed {
    in_item_t  it;
    logic      typed;
    out_item_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [TOL_W-1:0] cfg_wdata = '0;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int hold_left = 0;

  // Known answer for the first result of the directed transaction in flight.
  logic row_typed = 1'b0;
  out_item_t row_res = '0;

  // Directed stimulus table.
  dir_row_t dir_tab [$];

  // Predictor state.
  obs_t obs_q [NSRC][$];
  logic ovf_sticky = 1'b0;
  logic [TOL_W-1:0] tol_now = '0;
  out_item_t due_results [$];

  int unsigned n_in = 0;
  int unsigned n_out = 0;
  int unsigned n_fin = 0;
  int unsigned err_count = 0;

  multi_stream_timestamp_sync #(
    .NUM_SOURCES(NSRC),
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_item_t mk(logic [KIND_W-1:0] kind, logic [SRC_W-1:0] src,
                                  logic [63:0] ts, logic [TAG_W-1:0] tag);
    in_item_t it;
    it.kind = kind;
    it.source = src;
    it.timestamp = ts[TS_W-1:0];
    it.tag = tag;
    return it;
  endfunction

  task automatic add_row(in_item_t it, logic typed, out_item_t res);
    dir_row_t row;
    row.it = it;
    row.typed = typed;
    row.res = res;
    dir_tab.insert(dir_tab.size(), row);
  endtask

  task automatic report_mismatch(string what, logic [95:0] got, logic [95:0] want);
    $display("Mismatch on %s at output transaction %0d: got %0h, expected %0h",
             what, n_out, got, want);
    err_count++;
  endtask

  // Works out the results of one accepted transaction and queues them.
  task automatic sync_predict(in_item_t it, logic typed_on, out_item_t typed_res);
    logic [63:0] win_lo;
    logic [63:0] win_hi;
    logic have;
    int piv;
    int first_idx;
    out_item_t r;
    have = 1'b0;
    piv = 0;
    first_idx = due_results.size();
    case (it.kind)
      KIND_APPEND: begin
        if (obs_q[it.source].size() >= QDEPTH) ovf_sticky = 1'b1;
        else obs_q[it.source].insert(obs_q[it.source].size(), obs_t'({it.timestamp, it.tag}));
      end
      KIND_CLEAR: begin
        for (int s = 0; s < NSRC; s++) obs_q[s].delete();
      end
      KIND_ADVANCE: begin
        for (int s = 0; s < NSRC; s++) begin
          if (obs_q[s].size() != 0 && (!have || obs_q[s][0].ts < obs_q[piv][0].ts)) begin
            piv = s;
            have = 1'b1;
          end
        end
        if (!have) begin
          r = '0;
          r.finished = 1'b1;
          r.overflow = ovf_sticky;
          r.last = 1'b1;
          due_results.insert(due_results.size(), r);
        end else begin
          win_lo = {2'b00, obs_q[piv][0].ts};
          win_hi = win_lo + {32'd0, tol_now};
          for (int s = 0; s < NSRC; s++) begin
            r = '0;
            r.source_res = SRC_W'(s);
            r.overflow = ovf_sticky;
            r.last = (s == NSRC - 1);
            if (obs_q[s].size() != 0 && {2'b00, obs_q[s][0].ts} >= win_lo &&
                {2'b00, obs_q[s][0].ts} <= win_hi) begin
              r.present = 1'b1;
              r.timestamp_res = obs_q[s][0].ts;
              r.tag_res = obs_q[s][0].tag;
              void'(obs_q[s].pop_front());
            end
            due_results.insert(due_results.size(), r);
          end
        end
      end
      default: ;
    endcase
    if (typed_on && due_results.size() > first_idx) due_results[first_idx] = typed_res;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (due_results.size() == 0) begin
      report_mismatch("result with nothing due", 96'(got), '0);
    end else begin
      want = due_results.pop_front();
      if (got.source_res !== want.source_res)
        report_mismatch("source_res", 96'(got.source_res), 96'(want.source_res));
      if (got.present !== want.present)
        report_mismatch("present", 96'(got.present), 96'(want.present));
      if (got.timestamp_res !== want.timestamp_res)
        report_mismatch("timestamp_res", 96'(got.timestamp_res), 96'(want.timestamp_res));
      if (got.tag_res !== want.tag_res)
        report_mismatch("tag_res", 96'(got.tag_res), 96'(want.tag_res));
      if (got.finished !== want.finished)
        report_mismatch("finished", 96'(got.finished), 96'(want.finished));
      if (got.overflow !== want.overflow)
        report_mismatch("overflow", 96'(got.overflow), 96'(want.overflow));
      if (got.last !== want.last)
        report_mismatch("last", 96'(got.last), 96'(want.last));
    end
    if (got.finished === 1'b1) n_fin++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) tol_now = cfg_wdata;
      if (in_valid && !in_stall) begin
        n_in++;
        sync_predict(in_item, row_typed, row_res);
      end
      if (out_valid && !out_stall) begin
        n_out++;
        check_result(out_item);
      end
    end
  end

  // Receiver: a requested hold-off first, random stalls otherwise.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic drive_txn(in_item_t it, logic typed_on, out_item_t typed_res);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    row_typed = typed_on;
    row_res = typed_res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drops valid, waits for every due result and lets the block go quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic set_tolerance(logic [TOL_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Frames of near-simultaneous observations followed by advances, with some noise mixed in.
  task automatic run_traffic(int unsigned quota, logic [63:0] start_ts, int unsigned span);
    logic [63:0] base;
    logic [63:0] ts;
    logic [63:0] last_ts [NSRC];
    int unsigned counted;
    int rot;
    int src;
    in_item_t it;
    base = start_ts;
    counted = 0;
    for (int s = 0; s < NSRC; s++) last_ts[s] = '0;
    drive_txn(mk(KIND_CLEAR, 2'd0, 64'd0, 16'd0), 1'b0, '0);
    while (counted < quota) begin
      if ($urandom_range(0, 99) < 15) begin
        it = mk(KIND_W'($urandom_range(0, 3)), SRC_W'($urandom_range(0, 3)),
                {$urandom, $urandom}, TAG_W'($urandom));
        drive_txn(it, 1'b0, '0);
        if (it.kind != KIND_UNUSED) counted++;
      end else begin
        rot = $urandom_range(0, NSRC - 1);
        for (int k = 0; k < NSRC; k++) begin
          src = (rot + k) % NSRC;
          if ($urandom_range(0, 99) < 85) begin
            ts = base + 64'($urandom_range(0, span));
            // Now and then one source runs far ahead of the window.
            if ($urandom_range(0, 9) == 0) ts += 64'h1_0000_0000 * 64'($urandom_range(1, 3));
            if (ts < last_ts[src]) ts = last_ts[src];
            if (ts > TS_MAX) ts = TS_MAX;
            last_ts[src] = ts;
            drive_txn(mk(KIND_APPEND, SRC_W'(src), ts, TAG_W'($urandom)), 1'b0, '0);
            counted++;
          end
        end
        repeat ($urandom_range(1, 2)) begin
          drive_txn(mk(KIND_ADVANCE, SRC_W'($urandom), {$urandom, $urandom},
                       TAG_W'($urandom)), 1'b0, '0);
          counted++;
        end
        base += 64'(2 * span + $urandom_range(1, span + 1));
        if (base > TS_MAX) base = TS_MAX;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, at the reset tolerance of zero.
    add_row(mk(KIND_ADVANCE, 2'd0, 64'd0, 16'd0), 1'b1, FIN_CLEAN);
    add_row(mk(KIND_UNUSED, 2'd3, TS_MAX, 16'hFFFF), 1'b0, '0);
    add_row(mk(KIND_APPEND, 2'd0, TS_MAX, 16'hFFFF), 1'b0, '0);
    add_row(mk(KIND_ADVANCE, 2'd3, TS_MAX, 16'hFFFF), 1'b1, MAX_HEAD);
    add_row(mk(KIND_APPEND, 2'd3, 64'd0, 16'd0), 1'b0, '0);
    add_row(mk(KIND_APPEND, 2'd0, 64'd100, 16'h0001), 1'b0, '0);
    add_row(mk(KIND_APPEND, 2'd1, 64'd100, 16'h0002), 1'b0, '0);
    add_row(mk(KIND_APPEND, 2'd2, 64'd101, 16'h0003), 1'b0, '0);
    add_row(mk(KIND_ADVANCE, 2'd0, 64'd0, 16'd0), 1'b0, '0);
    // Two heads tie for the pivot here.
    add_row(mk(KIND_ADVANCE, 2'd0, 64'd0, 16'd0), 1'b0, '0);
    add_row(mk(KIND_ADVANCE, 2'd0, 64'd0, 16'd0), 1'b0, '0);
    add_row(mk(KIND_ADVANCE, 2'd0, 64'd0, 16'd0), 1'b1, FIN_CLEAN);
    // Out-of-order timestamps within one source stay in arrival order.
    add_row(mk(KIND_APPEND, 2'd2, 64'd500, 16'hAAAA), 1'b0, '0);
    add_row(mk(KIND_APPEND, 2'd2, 64'd200, 16'hBBBB), 1'b0, '0);
    add_row(mk(KIND_APPEND, 2'd1, 64'd300, 16'hCCCC), 1'b0, '0);
    add_row(mk(KIND_ADVANCE, 2'd0, 64'd0, 16'd0), 1'b0, '0);
    add_row(mk(KIND_ADVANCE, 2'd0, 64'd0, 16'd0), 1'b0, '0);
    add_row(mk(KIND_ADVANCE, 2'd0, 64'd0, 16'd0), 1'b0, '0);
    add_row(mk(KIND_APPEND, 2'd3, 64'd7, 16'h5555), 1'b0, '0);
    add_row(mk(KIND_APPEND, 2'd1, 64'd9, 16'h5A5A), 1'b0, '0);
    add_row(mk(KIND_CLEAR, 2'd3, TS_MAX, 16'hFFFF), 1'b0, '0);
    add_row(mk(KIND_ADVANCE, 2'd1, 64'd0, 16'd0), 1'b1, FIN_CLEAN);
    add_row(mk(KIND_UNUSED, 2'd0, 64'd0, 16'd0), 1'b0, '0);
    foreach (dir_tab[i]) drive_txn(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);

    // Narrow window, no idling on either side.
    set_tolerance(32'd25);
    run_traffic(25, 64'd1000, 60);

    // Widest window near the top of the timestamp range, sender often idle.
    set_tolerance(32'hFFFF_FFFF);
    idle_pct = 60;
    run_traffic(25, TS_MAX - 64'h2_0000_0000, 2000);

    // Exact match only, receiver stalling often.
    set_tolerance(32'd0);
    idle_pct = 0;
    stall_pct = 60;
    run_traffic(25, 64'd0, 3);

    // Receiver holds off while one queue is overfilled and advances pile up behind it.
    set_tolerance(32'd1000);
    stall_pct = 0;
    @(posedge clk);
    hold_left = 400;
    for (int i = 0; i < QDEPTH + 2; i++)
      drive_txn(mk(KIND_APPEND, 2'd1, 64'd1000 + 64'(10 * i), TAG_W'(i)), 1'b0, '0);
    drive_txn(mk(KIND_APPEND, 2'd0, 64'd1005, 16'h0F0F), 1'b0, '0);
    drive_txn(mk(KIND_APPEND, 2'd2, 64'd5000, 16'hF0F0), 1'b0, '0);
    repeat (8) drive_txn(mk(KIND_ADVANCE, 2'd0, 64'd0, 16'd0), 1'b0, '0);

    // Random window, light idling on both sides.
    set_tolerance($urandom);
    idle_pct = 11;
    stall_pct = 11;
    run_traffic(25, {12'd0, $urandom, 20'd0}, 2000);

    settle();
    $display("Covered %0d input and %0d output transactions over five window settings,",
             n_in, n_out);
    $display("including %0d empty-set results; overflow flag raised: %0d.", n_fin, ovf_sticky);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
